[sv/dofr_pkg.sv]
package dofr_pkg;

	localparam int MAX_FRAMES  = 8;
	localparam int FRAME_BYTES = 1024;
	localparam int SLOT_COUNT  = MAX_FRAMES + 2;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int OFS_W       = $clog2(FRAME_BYTES);
	localparam int LEN_W       = OFS_W + 1;
	localparam int QIDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int QCNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int MEM_DEPTH   = SLOT_COUNT * FRAME_BYTES;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_START = 2'd1,
		ACT_PULL  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_TRUNC   = 3'd2,
		ST_GRANT   = 3'd3,
		ST_REFUSE  = 3'd4,
		ST_BYTE    = 3'd5,
		ST_NOREAD  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_READ,
		CS_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [15:0] read_len;
		logic [15:0] buffer_capacity;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] sample_out;
		logic       is_padding;
		logic       last_of_frame;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic exec;     // run the captured item's state update
		logic rd_cap;   // capture memory read data into the result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_rd;  // item needs a memory read cycle
		logic no_out;   // item gives no result
	} dp_stat_t;

endpackage

[sv/dofr_if.sv]
interface dofr_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[sv/dofr_ram.sv]
module dofr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[sv/dofr_ctrl.sv]
module dofr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  dofr_pkg::dp_stat_t    stat,
	output dofr_pkg::dp_cmd_t     cmd
);
	dofr_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dofr_pkg::CS_IDLE;
		else         state_q <= state_d;
	end

	// one item at a time: accept, optional memory read, hold result
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			dofr_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.exec = 1'b1;
					if (stat.need_rd)      state_d = dofr_pkg::CS_READ;
					else if (!stat.no_out) state_d = dofr_pkg::CS_OUT;
				end
			end
			dofr_pkg::CS_READ: begin
				cmd.rd_cap = 1'b1;
				state_d    = dofr_pkg::CS_OUT;
			end
			dofr_pkg::CS_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = dofr_pkg::CS_IDLE;
			end
			default: state_d = dofr_pkg::CS_IDLE;
		endcase
	end
endmodule

[sv/dofr_dp.sv]
module dofr_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dofr_pkg::in_item_t    in_item,
	input  dofr_pkg::dp_cmd_t     cmd,
	output dofr_pkg::dp_stat_t    stat,
	output dofr_pkg::out_item_t   out_item
);
	localparam int SW = dofr_pkg::SLOT_W;
	localparam int OW = dofr_pkg::OFS_W;
	localparam int LW = dofr_pkg::LEN_W;
	localparam int QW = dofr_pkg::QIDX_W;
	localparam int CW = dofr_pkg::QCNT_W;
	localparam int NS = dofr_pkg::SLOT_COUNT;
	localparam int NQ = dofr_pkg::MAX_FRAMES;

	logic [LW-1:0] slot_len_q [NS];
	logic [NS-1:0] free_q;
	logic [SW-1:0] qord_q [NQ];
	logic [QW-1:0] qhead_q;
	logic [CW-1:0] qcnt_q;
	logic          fill_act_q;
	logic [SW-1:0] fill_slot_q;
	logic [LW-1:0] fill_cnt_q;
	logic          pend_v_q;
	logic [SW-1:0] pend_slot_q;
	logic [LW-1:0] pend_ofs_q;
	logic          rd_act_q, rd_exh_q;
	logic [15:0]   rd_rem_q;
	dofr_pkg::out_item_t res_q;

	// memory port signals
	logic                      mem_we;
	logic [dofr_pkg::ADDR_W-1:0] mem_wa, mem_ra;
	logic [7:0]                mem_rd;

	dofr_ram #(.WIDTH(8), .DEPTH(dofr_pkg::MEM_DEPTH)) u_store (
		.clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(in_item.data_byte),
		.raddr(mem_ra), .rdata(mem_rd)
	);

	// first free slot, priority encoded
	logic [SW-1:0] alloc_s;
	logic          alloc_ok;
	always_comb begin
		alloc_s  = '0;
		alloc_ok = 1'b0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				alloc_s  = SW'(i);
				alloc_ok = 1'b1;
			end
		end
	end

	function automatic logic [QW-1:0] qinc(input logic [QW-1:0] a);
		logic [QW:0] t;
		t = {1'b0, a} + 1'b1;
		if (t >= (QW+1)'(NQ)) t = '0;
		return t[QW-1:0];
	endfunction

	function automatic logic [QW-1:0] qadd(input logic [QW-1:0] a, input logic [CW-1:0] c);
		logic [QW+CW:0] t;
		t = (QW+CW+1)'(a) + (QW+CW+1)'(c);
		if (t >= (QW+CW+1)'(NQ)) t = t - (QW+CW+1)'(NQ);
		return t[QW-1:0];
	endfunction

	dofr_pkg::action_t act;
	assign act = dofr_pkg::action_t'(in_item.action);

	// pull-side decisions
	logic          pop_pend, take_data;
	logic [SW-1:0] rd_slot;
	logic [LW-1:0] rd_ofs;
	always_comb begin
		pop_pend  = rd_act_q && !rd_exh_q && !pend_v_q && (qcnt_q != '0);
		take_data = rd_act_q && !rd_exh_q && (pend_v_q || qcnt_q != '0);
		rd_slot   = pend_v_q ? pend_slot_q : qord_q[qhead_q];
		rd_ofs    = pend_v_q ? pend_ofs_q : '0;
	end

	assign mem_ra = dofr_pkg::ADDR_W'({rd_slot, rd_ofs[OW-1:0]});
	assign mem_we = cmd.exec && act == dofr_pkg::ACT_PUSH
		&& (fill_act_q || alloc_ok) && (fill_act_q ? fill_cnt_q : '0) < LW'(dofr_pkg::FRAME_BYTES);
	assign mem_wa = dofr_pkg::ADDR_W'({fill_act_q ? fill_slot_q : alloc_s,
		fill_act_q ? fill_cnt_q[OW-1:0] : {OW{1'b0}}});

	always_comb begin
		stat.need_rd = act == dofr_pkg::ACT_PULL && take_data;
		stat.no_out  = act == dofr_pkg::ACT_CLEAR;
	end

	assign out_item = res_q;

	// state update for one item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) slot_len_q[i] <= '0;
			free_q     <= '1;
			qhead_q    <= '0;
			qcnt_q     <= '0;
			fill_act_q <= 1'b0;
			fill_slot_q <= '0;
			fill_cnt_q <= '0;
			pend_v_q   <= 1'b0;
			pend_slot_q <= '0;
			pend_ofs_q <= '0;
			rd_act_q   <= 1'b0;
			rd_exh_q   <= 1'b0;
			rd_rem_q   <= '0;
			res_q      <= '0;
		end else if (cmd.rd_cap) begin
			res_q.sample_out <= mem_rd;
		end else if (cmd.exec) begin
			res_q <= '0;
			unique case (act)
				dofr_pkg::ACT_CLEAR: begin
					for (int i = 0; i < NS; i++) slot_len_q[i] <= '0;
					free_q     <= '1;
					qhead_q    <= '0;
					qcnt_q     <= '0;
					fill_act_q <= 1'b0;
					fill_cnt_q <= '0;
					pend_v_q   <= 1'b0;
					pend_ofs_q <= '0;
					rd_act_q   <= 1'b0;
					rd_exh_q   <= 1'b0;
					rd_rem_q   <= '0;
				end
				dofr_pkg::ACT_PUSH: begin : push
					logic [SW-1:0] fs;
					logic [LW-1:0] fc, nc;
					logic          trunc, drop;
					fs = fill_act_q ? fill_slot_q : alloc_s;
					fc = fill_act_q ? fill_cnt_q : '0;
					if (!fill_act_q && !alloc_ok) begin
						res_q.status <= dofr_pkg::ST_TRUNC;
					end else begin
						trunc = fc >= LW'(dofr_pkg::FRAME_BYTES);
						nc    = trunc ? fc : fc + 1'b1;
						drop  = in_item.frame_end && qcnt_q >= CW'(NQ);
						if (!fill_act_q) begin
							free_q[alloc_s] <= 1'b0;
							if (!in_item.frame_end) slot_len_q[alloc_s] <= '0;
						end
						if (in_item.frame_end) begin
							if (drop) begin
								free_q[qord_q[qhead_q]] <= 1'b1;
								qhead_q <= qinc(qhead_q);
								qord_q[qhead_q] <= fs;
							end else begin
								qord_q[qadd(qhead_q, qcnt_q)] <= fs;
								qcnt_q <= qcnt_q + 1'b1;
							end
							slot_len_q[fs] <= nc;
							fill_act_q <= 1'b0;
							fill_cnt_q <= '0;
						end else begin
							fill_act_q  <= 1'b1;
							fill_slot_q <= fs;
							fill_cnt_q  <= nc;
						end
						res_q.status <= trunc ? dofr_pkg::ST_TRUNC :
							(drop ? dofr_pkg::ST_DROPPED : dofr_pkg::ST_STORED);
					end
				end
				dofr_pkg::ACT_START: begin
					if (in_item.read_len == '0 || in_item.buffer_capacity == '0
						|| in_item.read_len > in_item.buffer_capacity
						|| (!pend_v_q && qcnt_q == '0)) begin
						res_q.status <= dofr_pkg::ST_REFUSE;
					end else begin
						rd_act_q <= 1'b1;
						rd_exh_q <= 1'b0;
						rd_rem_q <= in_item.read_len;
						res_q.status <= dofr_pkg::ST_GRANT;
					end
				end
				dofr_pkg::ACT_PULL: begin : pull
					logic [LW-1:0] no;
					logic          last;
					if (!rd_act_q) begin
						res_q.status <= dofr_pkg::ST_NOREAD;
					end else begin
						last = rd_rem_q == 16'd1;
						res_q.status <= dofr_pkg::ST_BYTE;
						res_q.last_of_frame <= last;
						res_q.is_padding <= !take_data;
						if (pop_pend) begin
							qhead_q <= qinc(qhead_q);
							qcnt_q  <= qcnt_q - 1'b1;
						end
						if (take_data) begin
							no = rd_ofs + 1'b1;
							if (no >= slot_len_q[rd_slot]) begin
								free_q[rd_slot] <= 1'b1;
								pend_v_q   <= 1'b0;
								pend_ofs_q <= '0;
							end else begin
								pend_v_q    <= 1'b1;
								pend_slot_q <= rd_slot;
								pend_ofs_q  <= no;
							end
						end
						rd_rem_q <= rd_rem_q - 1'b1;
						if (last) begin
							rd_act_q <= 1'b0;
							rd_exh_q <= 1'b0;
						end else if (!take_data) begin
							rd_exh_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[sv/drop_oldest_frame_rebuffer_core.sv]
// Drop-oldest audio frame queue with fixed-size output reframing.
// Channel in_ch carries items of action (push, start read, pull, clear)
// with a captured byte, a frame-end flag, a read length and a buffer size.
// Channel out_ch returns one result per item except clear: status,
// sample byte, padding flag and last-of-frame flag.
// Captured frames are held in ten slots of 1024 bytes in one byte memory
// with a write port and a registered read port; a frame is visible once its
// last byte is pushed. Committing a ninth queued frame drops the oldest one.
// One item is handled at a time. Push, start and a padding or idle pull
// show their result in the cycle after acceptance; a pull that fetches a
// byte first passes through a read state for the registered memory read.
// The next item is accepted once the result has been taken. Clear gives
// no result and leaves the controller idle.
// Reset empties the queue, drops any frame in progress and ends any read;
// the memory itself is not cleared. When the receiver stalls, the result
// holds on out_ch and no new item is accepted.
module drop_oldest_frame_rebuffer_core (
	input  logic clk,
	input  logic arst_n,
	dofr_if.sink   in_ch,
	dofr_if.source out_ch
);
	dofr_pkg::dp_cmd_t   cmd;
	dofr_pkg::dp_stat_t  stat;
	dofr_pkg::in_item_t  in_item;
	dofr_pkg::out_item_t out_item;

	assign in_item = dofr_pkg::in_item_t'(in_ch.payload);
	assign out_ch.payload = out_item;

	dofr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	dofr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item),
		.cmd(cmd), .stat(stat), .out_item(out_item)
	);

	// no acceptance while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");

	// read-capture always follows an exec
	a_rd_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_cap |-> $past(cmd.exec)) else $error("stray read capture");

	// a fetched byte is never flagged as padding
	a_rd_not_pad: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_cap |=> (out_ch.valid && !out_ch.payload[1]))
		else $error("fetched byte marked padding");
endmodule

[verif/tb_dofr_checker.sv]
`timescale 1ns / 1ps

module tb_dofr_checker
	import dofr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	dofr_if      in_ch,
	dofr_if      out_ch,
	output int   errors,
	output int   waiting
);

	// shadow of the frame queue
	logic [7:0] frame_mem [SLOT_COUNT][FRAME_BYTES];
	int         frame_len [SLOT_COUNT];
	int         order_q [MAX_FRAMES];
	int         q_head, q_cnt;
	bit         slot_free [SLOT_COUNT];
	bit         filling;
	int         fill_slot, fill_cnt;
	bit         pend_on;
	int         pend_slot, pend_ofs;
	bit         rd_on, rd_dry;
	int         rd_left;

	out_item_t  want_q[$];

	assign waiting = want_q.size();

	function automatic void empty_queue();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_free[i] = 1'b1;
			frame_len[i] = 0;
		end
		q_head = 0;
		q_cnt = 0;
		filling = 1'b0;
		fill_slot = 0;
		fill_cnt = 0;
		pend_on = 1'b0;
		pend_slot = 0;
		pend_ofs = 0;
		rd_on = 1'b0;
		rd_dry = 1'b0;
		rd_left = 0;
	endfunction

	function automatic int pop_oldest();
		int s;
		s = order_q[q_head];
		q_head = (q_head + 1) % MAX_FRAMES;
		q_cnt--;
		return s;
	endfunction

	// capture side: store byte, commit frame on its last byte
	function automatic status_t store_byte(logic [7:0] b, logic last);
		status_t st;
		bit      dropped;
		int      s;
		st = ST_STORED;
		dropped = 1'b0;
		if (!filling) begin
			s = -1;
			for (int i = 0; i < SLOT_COUNT; i++)
				if (s < 0 && slot_free[i]) s = i;
			if (s < 0) return ST_TRUNC;
			slot_free[s] = 1'b0;
			frame_len[s] = 0;
			filling = 1'b1;
			fill_slot = s;
			fill_cnt = 0;
		end
		if (fill_cnt < FRAME_BYTES) begin
			frame_mem[fill_slot][fill_cnt] = b;
			fill_cnt++;
		end else begin
			st = ST_TRUNC;
		end
		if (last) begin
			if (q_cnt >= MAX_FRAMES) begin
				slot_free[pop_oldest()] = 1'b1;
				dropped = 1'b1;
			end
			frame_len[fill_slot] = fill_cnt;
			order_q[(q_head + q_cnt) % MAX_FRAMES] = fill_slot;
			q_cnt++;
			filling = 1'b0;
			fill_cnt = 0;
		end
		if (st == ST_STORED && dropped) st = ST_DROPPED;
		return st;
	endfunction

	// reader side: one output byte, data first then silence
	function automatic void pull_byte(ref out_item_t r);
		if (!rd_on) begin
			r.status = ST_NOREAD;
			return;
		end
		if (!rd_dry && !pend_on) begin
			if (q_cnt > 0) begin
				pend_slot = pop_oldest();
				pend_ofs = 0;
				pend_on = 1'b1;
			end else begin
				rd_dry = 1'b1;
			end
		end
		if (!rd_dry && pend_on) begin
			r.sample_out = frame_mem[pend_slot][pend_ofs];
			pend_ofs++;
			if (pend_ofs >= frame_len[pend_slot]) begin
				slot_free[pend_slot] = 1'b1;
				pend_on = 1'b0;
				pend_ofs = 0;
			end
		end else begin
			r.is_padding = 1'b1;
		end
		rd_left--;
		if (rd_left == 0) begin
			r.last_of_frame = 1'b1;
			rd_on = 1'b0;
			rd_dry = 1'b0;
		end
		r.status = ST_BYTE;
	endfunction

	// returns 0 when the item gives no result
	function automatic bit predict_result(in_item_t it, output out_item_t r);
		r = '0;
		case (action_t'(it.action))
			ACT_CLEAR: begin
				empty_queue();
				return 1'b0;
			end
			ACT_PUSH: r.status = store_byte(it.data_byte, it.frame_end);
			ACT_START: begin
				if (it.read_len == 0 || it.buffer_capacity == 0 ||
				    it.read_len > it.buffer_capacity || (!pend_on && q_cnt == 0)) begin
					r.status = ST_REFUSE;
				end else begin
					rd_on = 1'b1;
					rd_dry = 1'b0;
					rd_left = it.read_len;
					r.status = ST_GRANT;
				end
			end
			default: pull_byte(r);
		endcase
		return 1'b1;
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		out_item_t want, got;
		if (!arst_n) begin
			empty_queue();
			want_q.delete();
			errors <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_item_t'(out_ch.payload);
				if (want_q.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = want_q[0];
					want_q.delete(0);
					if (got !== want) begin
						$display({"%0t: mismatch exp st=%0d smp=%h pad=%b last=%b",
							" got st=%0d smp=%h pad=%b last=%b"},
							$time, want.status, want.sample_out, want.is_padding,
							want.last_of_frame, got.status, got.sample_out,
							got.is_padding, got.last_of_frame);
						errors <= errors + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (predict_result(in_item_t'(in_ch.payload), want))
					want_q.push_back(want);
			end
		end
	end

endmodule

[verif/tb_drop_oldest_frame_rebuffer_core.sv]
`timescale 1ns / 1ps

module tb_drop_oldest_frame_rebuffer_core;
	import dofr_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, waiting;
	int   idle_pct, stall_pct;
	int   quiet_cycles;
	int   sent;

	dofr_if #(.W($bits(in_item_t)))  in_ch();
	dofr_if #(.W($bits(out_item_t))) out_ch();

	drop_oldest_frame_rebuffer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	tb_dofr_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.waiting (waiting)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic in_item_t mk(action_t a, logic [7:0] b, logic e,
		logic [15:0] len, logic [15:0] cap);
		in_item_t it;
		it.action = a;
		it.data_byte = b;
		it.frame_end = e;
		it.read_len = len;
		it.buffer_capacity = cap;
		return it;
	endfunction

	task automatic send(input in_item_t it);
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	task automatic push_frame(int n);
		for (int i = 0; i < n; i++)
			send(mk(ACT_PUSH, 8'($urandom_range(255)), i == n - 1,
				16'($urandom_range(65535)), 16'($urandom_range(65535))));
	endtask

	task automatic pulls(int n);
		for (int i = 0; i < n; i++)
			send(mk(ACT_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)),
				16'($urandom_range(65535)), 16'($urandom_range(65535))));
	endtask

	// one random scenario: mostly well-formed frames and reads
	task automatic random_step();
		int pick, len;
		pick = $urandom_range(99);
		if (pick < 38) begin
			push_frame($urandom_range(1, 12));
		end else if (pick < 60) begin
			len = $urandom_range(1, 30);
			send(mk(ACT_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
				16'(len), 16'(len + $urandom_range(0, 40))));
		end else if (pick < 88) begin
			pulls($urandom_range(1, 16));
		end else if (pick < 91) begin
			send(mk(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
				16'($urandom_range(65535)), 16'($urandom_range(65535))));
		end else begin
			send(mk(action_t'(2'($urandom_range(3))), 8'($urandom_range(255)),
				1'($urandom_range(1)), 16'($urandom_range(65535)),
				16'($urandom_range(65535))));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle pull, refusals, padding, drop, replacement, clear
		send(mk(ACT_PULL, 8'hff, 1'b1, 16'hffff, 16'hffff));
		send(mk(ACT_START, 8'h00, 1'b0, 16'd4, 16'd4));
		push_frame(2);
		send(mk(ACT_START, 8'h00, 1'b0, 16'd0, 16'd5));
		send(mk(ACT_START, 8'h00, 1'b0, 16'd5, 16'd0));
		send(mk(ACT_START, 8'h00, 1'b0, 16'hffff, 16'hfffe));
		send(mk(ACT_START, 8'h00, 1'b0, 16'd5, 16'd5));
		pulls(5);
		for (int i = 0; i < 9; i++) push_frame(1);
		send(mk(ACT_START, 8'h00, 1'b0, 16'hffff, 16'hffff));
		pulls(3);
		send(mk(ACT_START, 8'h00, 1'b0, 16'd2, 16'd3));
		pulls(2);
		send(mk(ACT_CLEAR, 8'h00, 1'b0, 16'd0, 16'd0));
		send(mk(ACT_PULL, 8'h00, 1'b0, 16'd0, 16'd0));
		drain();

		// full queue: one more committed frame drops the oldest
		for (int i = 0; i < MAX_FRAMES; i++) push_frame(1);
		push_frame(3);
		send(mk(ACT_START, 8'h00, 1'b0, 16'd40, 16'd40));
		pulls(12);
		drain();

		// random phases with different idle and stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 60 : (ph == 3) ? 33 : 0;
			stall_pct = (ph == 2) ? 60 : (ph == 3) ? 33 : 0;
			sent = 0;
			while (sent < 145) random_step();
			drain();
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
